// ===== rtl/core/scsa_pkg.sv =====
// ----------------------------------------------------------------------------
// scsa_pkg
// Shared types, codes and constants of the size-class slab allocator.
// ----------------------------------------------------------------------------
package scsa_pkg;

    localparam int BLOCK_W     = 18;
    localparam int SIZE_W      = 20;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int CLS_W       = 4;
    localparam int MAX_CLASSES = 16;

    localparam int DEF_PAGE_BYTES = 4096;
    localparam int DEF_WORD_BYTES = 8;
    localparam int DEF_POOL_PAGES = 64;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CLASS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_PAGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_UNOWNED  = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SIZE_W-1:0]  req_size;
        logic [BLOCK_W-1:0] old_block;
        logic               old_present;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  block_addr;
    } out_item_t;

    // Classes whose block size is at most a quarter page.
    function automatic int class_count(int page_bytes, int word_bytes);
        int n;
        n = 0;
        for (int c = 0; c < MAX_CLASSES; c++) begin
            if (4 * (word_bytes << c) <= page_bytes) begin
                n = c + 1;
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/size_class_slab_allocator_top.sv =====
// ----------------------------------------------------------------------------
// size_class_slab_allocator_top
// Slab allocator: power-of-two size classes, per-class freed stacks threaded
// through a link memory, per-class bump walk over the newest page.
// ----------------------------------------------------------------------------
// Flow: an item is taken in IDLE, resolved in EXEC, then passes an optional
//   POP and/or PUSH of a freed stack and DONE, where the result is registered;
//   DONE waits while the previous result is still held. No new item is taken
//   until the block is back in IDLE, so it handles one item at a time.
// Reset: synchronous, active low; class i starts on page i, freed stacks
//   empty. The link memory needs no clearing pass.
module size_class_slab_allocator_top
    import scsa_pkg::*;
#(
    parameter int PAGE_BYTES = DEF_PAGE_BYTES,
    parameter int WORD_BYTES = DEF_WORD_BYTES,
    parameter int POOL_PAGES = DEF_POOL_PAGES
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int PAGE_SH    = $clog2(PAGE_BYTES);
    localparam int WORD_SH    = $clog2(WORD_BYTES);
    localparam int POOL_BYTES = POOL_PAGES * PAGE_BYTES;
    localparam int PA_W       = $clog2(POOL_BYTES);
    localparam int LINK_WORDS = POOL_BYTES / WORD_BYTES;
    localparam int LINK_W     = PA_W + 1;
    localparam int PG_W       = $clog2(POOL_PAGES);
    localparam int NP_W       = $clog2(POOL_PAGES + 1);
    localparam int CLASS_NUM  = class_count(PAGE_BYTES, WORD_BYTES);
    localparam int INIT_PAGES = (CLASS_NUM < POOL_PAGES) ? CLASS_NUM : POOL_PAGES;
    localparam int BB_W       = SIZE_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_PUSH = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    function automatic logic [CLS_W:0] find_class(logic [SIZE_W-1:0] size);
        logic [CLS_W:0] r;
        r = '0;
        for (int c = CLASS_NUM - 1; c >= 0; c--) begin
            if ({1'b0, size} <= BB_W'(WORD_BYTES << c)) begin
                r = {1'b1, CLS_W'(c)};
            end
        end
        return r;
    endfunction

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [CMD_W-1:0]    cmd_reg;
    logic [BLOCK_W-1:0]  old_reg;
    logic                present_reg;
    logic                fits_reg;
    logic [CLS_W-1:0]    cls_reg;
    logic [CLS_W-1:0]    own_cls_reg;
    logic [NP_W-1:0]     next_page_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [PA_W-1:0]     res_addr_reg;
    logic                m_valid_reg;
    out_item_t           m_data_reg;

    logic [PA_W-1:0] freed_top_reg  [MAX_CLASSES];
    logic            freed_valid_reg[MAX_CLASSES];
    logic [PA_W-1:0] bump_next_reg  [MAX_CLASSES];
    logic            bump_valid_reg [MAX_CLASSES];

    logic [LINK_W-1:0] link_mem [LINK_WORDS];
    logic [LINK_W-1:0] link_q;
    logic [CLS_W-1:0]  owner_mem [POOL_PAGES];
    logic [CLS_W-1:0]  owner_q;

    logic [CLS_W-1:0]   sel_cls;
    logic [PA_W-1:0]    freed_top_sel;
    logic               freed_valid_sel;
    logic [PA_W-1:0]    bump_next_sel;
    logic               bump_valid_sel;
    logic [BLOCK_W-1:0] old_page;
    logic               taken;
    logic [CLS_W-1:0]   own_cls;
    logic               unowned;
    logic               do_alloc;
    logic               do_free;
    logic               push_after;
    logic               no_page;
    logic [PA_W-1:0]    bs;
    logic [PA_W-1:0]    open_base;
    logic [PA_W-1:0]    bump_cur;
    logic [PA_W:0]      bump_sum;
    logic               page_end;
    logic [PA_W-1:0]    old_addr;
    logic               out_free;
    logic               owner_we;
    logic               link_we;

    assign sel_cls         = (state_reg == S_PUSH) ? own_cls_reg : cls_reg;
    assign freed_top_sel   = freed_top_reg[sel_cls];
    assign freed_valid_sel = freed_valid_reg[sel_cls];
    assign bump_next_sel   = bump_next_reg[sel_cls];
    assign bump_valid_sel  = bump_valid_reg[sel_cls];

    assign old_page   = old_reg >> PAGE_SH;
    assign taken      = old_page < BLOCK_W'(next_page_reg);
    assign own_cls    = (old_page < BLOCK_W'(INIT_PAGES)) ? CLS_W'(old_page) : owner_q;
    assign old_addr   = PA_W'(old_reg);
    assign push_after = (cmd_reg == CMD_REALLOC) && present_reg;
    assign unowned    = ((cmd_reg == CMD_FREE) || (cmd_reg == CMD_REALLOC)) &&
                        present_reg && !taken;
    assign do_alloc   = (cmd_reg == CMD_ALLOC) || ((cmd_reg == CMD_REALLOC) && !unowned);
    assign do_free    = (cmd_reg == CMD_FREE) && present_reg && taken;
    assign no_page    = !bump_valid_sel && (next_page_reg >= NP_W'(POOL_PAGES));

    assign bs        = PA_W'(WORD_BYTES) << cls_reg;
    assign open_base = {next_page_reg[PG_W-1:0], {PAGE_SH{1'b0}}};
    assign bump_cur  = bump_valid_sel ? bump_next_sel : (open_base | bs);
    assign bump_sum  = {1'b0, bump_cur} + {1'b0, bs};
    assign page_end  = (bump_sum[PAGE_SH-1:0] == '0);

    assign out_free = !m_valid_reg || m_ready;
    assign owner_we = (state_reg == S_EXEC) && !unowned && do_alloc && fits_reg &&
                      !freed_valid_sel && !bump_valid_sel && !no_page;
    assign link_we  = (state_reg == S_PUSH);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                if (unowned) begin
                    state_next = S_DONE;
                end else if (do_alloc) begin
                    if (!fits_reg || (!freed_valid_sel && no_page)) begin
                        state_next = S_DONE;
                    end else if (freed_valid_sel) begin
                        state_next = S_POP;
                    end else begin
                        state_next = push_after ? S_PUSH : S_DONE;
                    end
                end else if (do_free) begin
                    state_next = S_PUSH;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_POP: begin
                state_next = push_after ? S_PUSH : S_DONE;
            end
            S_PUSH: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            m_valid_reg   <= 1'b0;
            next_page_reg <= NP_W'(INIT_PAGES);
            for (int c = 0; c < MAX_CLASSES; c++) begin
                freed_valid_reg[c] <= 1'b0;
                bump_valid_reg[c]  <= (c < INIT_PAGES);
                bump_next_reg[c]   <= PA_W'(c * PAGE_BYTES + (WORD_BYTES << c));
            end
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg             <= s_data.cmd;
                        old_reg             <= s_data.old_block;
                        present_reg         <= s_data.old_present;
                        {fits_reg, cls_reg} <= find_class(s_data.req_size);
                    end
                end
                S_EXEC: begin
                    own_cls_reg    <= own_cls;
                    res_status_reg <= ST_OK;
                    res_addr_reg   <= '0;
                    if (unowned) begin
                        res_status_reg <= ST_UNOWNED;
                    end else if (do_alloc) begin
                        if (!fits_reg) begin
                            res_status_reg <= ST_NO_CLASS;
                        end else if (freed_valid_sel) begin
                            res_addr_reg <= freed_top_sel;
                        end else if (no_page) begin
                            res_status_reg <= ST_NO_PAGE;
                        end else begin
                            res_addr_reg            <= bump_cur;
                            bump_next_reg[sel_cls]  <= bump_sum[PA_W-1:0];
                            bump_valid_reg[sel_cls] <= !page_end;
                            if (!bump_valid_sel) begin
                                next_page_reg <= next_page_reg + 1'b1;
                            end
                        end
                    end
                end
                S_POP: begin
                    freed_top_reg[sel_cls]   <= link_q[PA_W-1:0];
                    freed_valid_reg[sel_cls] <= link_q[PA_W];
                end
                S_PUSH: begin
                    freed_top_reg[sel_cls]   <= old_addr;
                    freed_valid_reg[sel_cls] <= 1'b1;
                end
                S_DONE: begin
                    if (out_free) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.status     <= res_status_reg;
                        m_data_reg.block_addr <= BLOCK_W'(res_addr_reg);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Link memory: next pointer and valid bit of each freed block.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[old_addr[PA_W-1:WORD_SH]] <= {freed_valid_sel, freed_top_sel};
        end
        link_q <= link_mem[freed_top_sel[PA_W-1:WORD_SH]];
    end

    // Page owner memory; initial pages are decoded, not stored.
    always_ff @(posedge aclk) begin
        if (owner_we) begin
            owner_mem[next_page_reg[PG_W-1:0]] <= cls_reg;
        end
        owner_q <= owner_mem[PG_W'(s_data.old_block >> PAGE_SH)];
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== rtl/core/scsa_checker.sv =====
// ----------------------------------------------------------------------------
// scsa_checker
// Port-level checks of the slab allocator, bound to the top level.
// ----------------------------------------------------------------------------
module scsa_checker
    import scsa_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // One item in flight: no new transfer right after one is taken.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after transfer");

    // A result never appears the cycle after an input transfer.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result too early");

    // Failed requests carry a zero address.
    a_fail_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.status == ST_OK || m_data.block_addr == '0))
        else $error("nonzero address on failure");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result dropped or changed while stalled");

endmodule

bind size_class_slab_allocator_top scsa_checker u_scsa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-class slab allocator. Corner cases,
// mixed allocate/free/reallocate traffic, a long result-side stall and
// exhaustion of the page pool. Every result is checked against an
// in-bench allocator kept in step with each accepted request.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scsa_pkg::*;

    localparam int PAGE_BYTES = DEF_PAGE_BYTES;
    localparam int WORD_BYTES = DEF_WORD_BYTES;
    localparam int POOL_PAGES = DEF_POOL_PAGES;
    localparam int LINK_DEPTH = POOL_PAGES * PAGE_BYTES / WORD_BYTES;
    localparam int TOP_BYTES  = PAGE_BYTES / 4;
    localparam int SIZE_MAX   = 2 ** SIZE_W - 1;
    localparam int ADDR_MAX   = 2 ** BLOCK_W - 1;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    size_class_slab_allocator_top #(
        .PAGE_BYTES(PAGE_BYTES),
        .WORD_BYTES(WORD_BYTES),
        .POOL_PAGES(POOL_PAGES)
    ) u_top (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data (s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data (m_data)
    );

    // allocator state mirror
    logic [BLOCK_W-1:0] link_next  [LINK_DEPTH];
    bit                 link_live  [LINK_DEPTH];
    logic [BLOCK_W-1:0] stack_head [MAX_CLASSES];
    bit                 stack_live [MAX_CLASSES];
    int unsigned        walk_addr  [MAX_CLASSES];
    bit                 walk_live  [MAX_CLASSES];
    int unsigned        page_class [POOL_PAGES];
    int unsigned        pages_taken;
    int unsigned        num_classes;

    out_item_t   predicted_replies[$];
    int unsigned live_blocks[$];

    bit no_idle;
    int stall_request;
    int error_count;
    int sent_count;
    int checked_count;
    int cmd_count[4];
    int status_count[4];

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #3000000;
        $display("Timeout: %0d results still outstanding", predicted_replies.size());
        $display("** size_class_slab_allocator_top: FAILED **");
        $finish;
    end

    function automatic int unsigned block_size(int unsigned c);
        return WORD_BYTES << c;
    endfunction

    function automatic void start_page(int unsigned c, int unsigned p);
        page_class[p] = c;
        walk_addr[c]  = p * PAGE_BYTES + block_size(c);
        walk_live[c]  = 2 * block_size(c) <= PAGE_BYTES;
    endfunction

    function automatic void slab_reset();
        num_classes = 0;
        while (num_classes < MAX_CLASSES && block_size(num_classes) <= TOP_BYTES) begin
            num_classes++;
        end
        for (int c = 0; c < MAX_CLASSES; c++) begin
            stack_head[c] = '0;
            stack_live[c] = 1'b0;
            walk_addr[c]  = 0;
            walk_live[c]  = 1'b0;
        end
        for (int p = 0; p < POOL_PAGES; p++) begin
            page_class[p] = 0;
        end
        for (int i = 0; i < LINK_DEPTH; i++) begin
            link_next[i] = '0;
            link_live[i] = 1'b0;
        end
        pages_taken = 0;
        for (int unsigned c = 0; c < num_classes && c < POOL_PAGES; c++) begin
            start_page(c, c);
            pages_taken++;
        end
    endfunction

    function automatic logic [STATUS_W-1:0] carve_block(input int unsigned size,
                                                         output int unsigned addr);
        int unsigned c;
        int unsigned li;
        bit          found;
        addr  = 0;
        c     = 0;
        found = 1'b0;
        for (int unsigned k = 0; k < num_classes && !found; k++) begin
            if (block_size(k) >= size) begin
                c     = k;
                found = 1'b1;
            end
        end
        if (!found) begin
            return ST_NO_CLASS;
        end
        if (stack_live[c]) begin
            addr          = stack_head[c];
            li            = (addr / WORD_BYTES) % LINK_DEPTH;
            stack_head[c] = link_next[li];
            stack_live[c] = link_live[li];
            return ST_OK;
        end
        if (!walk_live[c]) begin
            if (pages_taken >= POOL_PAGES) begin
                return ST_NO_PAGE;
            end
            start_page(c, pages_taken);
            pages_taken++;
        end
        addr         = walk_addr[c];
        walk_addr[c] = addr + block_size(c);
        if (walk_addr[c] % PAGE_BYTES == 0) begin
            walk_live[c] = 1'b0;
        end
        return ST_OK;
    endfunction

    function automatic void push_freed(int unsigned addr);
        int unsigned c;
        int unsigned li;
        c             = page_class[addr / PAGE_BYTES] % MAX_CLASSES;
        li            = (addr / WORD_BYTES) % LINK_DEPTH;
        link_next[li] = stack_head[c];
        link_live[li] = stack_live[c];
        stack_head[c] = BLOCK_W'(addr);
        stack_live[c] = 1'b1;
    endfunction

    function automatic out_item_t slab_reply(in_item_t it);
        out_item_t   r;
        int unsigned got;
        int unsigned old;
        bit          owned;
        r.status     = ST_OK;
        r.block_addr = '0;
        got          = 0;
        old          = it.old_block;
        owned        = (old / PAGE_BYTES) < pages_taken;
        case (it.cmd)
            CMD_ALLOC: begin
                r.status = carve_block(it.req_size, got);
                if (r.status == ST_OK) begin
                    r.block_addr = BLOCK_W'(got);
                end
            end
            CMD_FREE: begin
                if (it.old_present) begin
                    if (owned) begin
                        push_freed(old);
                    end else begin
                        r.status = ST_UNOWNED;
                    end
                end
            end
            CMD_REALLOC: begin
                if (it.old_present && !owned) begin
                    r.status = ST_UNOWNED;
                end else begin
                    r.status = carve_block(it.req_size, got);
                    if (r.status == ST_OK) begin
                        r.block_addr = BLOCK_W'(got);
                        if (it.old_present) begin
                            push_freed(old);
                        end
                    end
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic int unsigned size_in_class(int unsigned c);
        return $urandom_range(c == 0 ? 0 : block_size(c - 1) + 1, block_size(c));
    endfunction

    function automatic int unsigned pick_live();
        return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    endfunction

    function automatic void forget_block(int unsigned addr);
        for (int i = 0; i < live_blocks.size(); i++) begin
            if (live_blocks[i] == addr) begin
                live_blocks.delete(i);
                return;
            end
        end
    endfunction

    // One request transfer; valid stays up afterwards so back-to-back items
    // need no extra edge. The mirror advances at acceptance.
    task automatic issue(input logic [CMD_W-1:0] cmd, input int unsigned size,
                         input int unsigned old, input bit present,
                         output out_item_t res);
        in_item_t it;
        int       gap;
        it.cmd         = cmd;
        it.req_size    = size[SIZE_W-1:0];
        it.old_block   = old[BLOCK_W-1:0];
        it.old_present = present;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data  <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        res = slab_reply(it);
        predicted_replies.push_back(res);
        sent_count++;
        cmd_count[it.cmd]++;
        if (res.status == ST_OK) begin
            if ((cmd == CMD_FREE || cmd == CMD_REALLOC) && present) begin
                forget_block(it.old_block);
            end
            if (cmd == CMD_ALLOC || cmd == CMD_REALLOC) begin
                live_blocks.push_back(res.block_addr);
            end
        end
    endtask

    task automatic sender_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (predicted_replies.size() != 0) @(posedge aclk);
    endtask

    task automatic run_mixed_traffic(input int n);
        out_item_t   res;
        int unsigned roll;
        int unsigned a;
        for (int i = 0; i < n; i++) begin
            no_idle = (i % 120) >= 80;
            roll    = $urandom_range(0, 99);
            if (roll < 40 || live_blocks.size() == 0) begin
                issue(CMD_ALLOC, size_in_class($urandom_range(0, num_classes - 1)),
                      $urandom, 1'($urandom), res);
            end else if (roll < 65) begin
                issue(CMD_FREE, $urandom, pick_live(), 1'b1, res);
            end else if (roll < 78) begin
                issue(CMD_REALLOC, size_in_class($urandom_range(0, num_classes - 1)),
                      pick_live(), 1'b1, res);
            end else if (roll < 84) begin
                issue(CMD_REALLOC, size_in_class($urandom_range(0, num_classes - 1)),
                      $urandom, 1'b0, res);
            end else begin
                case ($urandom_range(0, 4))
                    0: issue(CMD_W'($urandom_range(0, 3)), $urandom, $urandom,
                             1'($urandom), res);
                    1: issue(CMD_ALLOC, $urandom_range(TOP_BYTES + 1, SIZE_MAX),
                             $urandom, 1'($urandom), res);
                    2: issue(CMD_FREE, $urandom,
                             $urandom_range(0, pages_taken * PAGE_BYTES - 1), 1'b1, res);
                    3: begin
                        if (pages_taken < POOL_PAGES) begin
                            a = $urandom_range(pages_taken * PAGE_BYTES, ADDR_MAX);
                        end else begin
                            a = $urandom;
                        end
                        issue($urandom_range(0, 1) ? CMD_FREE : CMD_REALLOC,
                              $urandom_range(0, TOP_BYTES), a, 1'b1, res);
                    end
                    default: issue(CMD_FREE, $urandom, $urandom, 1'b0, res);
                endcase
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_corner_cases();
        out_item_t   res;
        int unsigned first;
        int unsigned second;
        int unsigned big;
        issue(CMD_ALLOC, 0, 0, 1'b0, res);
        first = res.block_addr;
        issue(CMD_ALLOC, 1, 0, 1'b0, res);
        second = res.block_addr;
        issue(CMD_ALLOC, WORD_BYTES + 1, 0, 1'b0, res);
        issue(CMD_ALLOC, TOP_BYTES, 0, 1'b0, res);
        big = res.block_addr;
        issue(CMD_ALLOC, TOP_BYTES + 1, 0, 1'b0, res);
        issue(CMD_ALLOC, SIZE_MAX, ADDR_MAX, 1'b1, res);
        issue(CMD_ALLOC, 32, 0, 1'b0, res);
        issue(CMD_ALLOC, 256, 0, 1'b0, res);
        issue(CMD_ALLOC, 512, 0, 1'b0, res);
        // null free, then free and realloc of a never-taken page
        issue(CMD_FREE, 0, ADDR_MAX, 1'b0, res);
        issue(CMD_FREE, 0, ADDR_MAX, 1'b1, res);
        issue(CMD_REALLOC, 8, ADDR_MAX, 1'b1, res);
        // freed stack is LIFO
        issue(CMD_FREE, 0, first, 1'b1, res);
        issue(CMD_ALLOC, 5, 0, 1'b0, res);
        first = res.block_addr;
        // double free hands the block out twice
        issue(CMD_FREE, 0, second, 1'b1, res);
        issue(CMD_FREE, 0, second, 1'b1, res);
        issue(CMD_ALLOC, 1, 0, 1'b0, res);
        issue(CMD_ALLOC, 1, 0, 1'b0, res);
        // page header and unaligned offsets are pushed as given
        issue(CMD_FREE, 0, 0, 1'b1, res);
        issue(CMD_ALLOC, 0, 0, 1'b0, res);
        issue(CMD_FREE, 0, PAGE_BYTES + 19, 1'b1, res);
        issue(CMD_ALLOC, 2 * WORD_BYTES, 0, 1'b0, res);
        // realloc: null old, success frees old, failure keeps old
        issue(CMD_REALLOC, 100, ADDR_MAX, 1'b0, res);
        issue(CMD_REALLOC, 200, big, 1'b1, res);
        issue(CMD_ALLOC, TOP_BYTES, 0, 1'b0, res);
        issue(CMD_REALLOC, 2 * TOP_BYTES, first, 1'b1, res);
        issue(CMD_NOP, SIZE_MAX, ADDR_MAX, 1'b1, res);
        sender_idle();
    endtask

    task automatic test_mixed_traffic();
        run_mixed_traffic(260);
        sender_idle();
    endtask

    // Result side held off while requests keep coming, so the block backs up.
    task automatic test_output_stall();
        out_item_t res;
        wait_drained();
        no_idle       = 1'b1;
        stall_request = 150;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 == 2 && live_blocks.size() > 0) begin
                issue(CMD_FREE, 0, pick_live(), 1'b1, res);
            end else begin
                issue(CMD_ALLOC, size_in_class($urandom_range(0, num_classes - 1)),
                      0, 1'b0, res);
            end
        end
        no_idle = 1'b0;
        sender_idle();
    endtask

    task automatic test_page_exhaustion();
        out_item_t   res;
        int unsigned last_big;
        int          n;
        n        = 0;
        last_big = 0;
        do begin
            issue(CMD_ALLOC, TOP_BYTES, 0, 1'b0, res);
            if (res.status == ST_OK) begin
                last_big = res.block_addr;
            end
            n++;
        end while (res.status != ST_NO_PAGE && n < 300);
        // failed realloc must leave the old block allocated
        issue(CMD_REALLOC, TOP_BYTES, pick_live(), 1'b1, res);
        issue(CMD_FREE, 0, last_big, 1'b1, res);
        issue(CMD_ALLOC, TOP_BYTES - 1, 0, 1'b0, res);
        for (int i = 0; i < 12; i++) begin
            issue(CMD_ALLOC, size_in_class(num_classes - 2), 0, 1'b0, res);
        end
        run_mixed_traffic(50);
        sender_idle();
    endtask

    initial begin : result_checker
        int        stall;
        out_item_t want;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (stall_request > 0) begin
                stall         = stall_request;
                stall_request = 0;
            end else begin
                stall = draw_gap();
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            checked_count++;
            if (predicted_replies.size() == 0) begin
                error_count++;
                $display("%0t ns: result with nothing outstanding: status %0d addr 0x%05h",
                         $time, m_data.status, m_data.block_addr);
            end else begin
                want = predicted_replies.pop_front();
                status_count[want.status]++;
                if (m_data.status !== want.status) begin
                    error_count++;
                    $display("%0t ns: status expected %0d, actual %0d",
                             $time, want.status, m_data.status);
                end
                if (m_data.block_addr !== want.block_addr) begin
                    error_count++;
                    $display("%0t ns: block_addr expected 0x%05h, actual 0x%05h",
                             $time, want.block_addr, m_data.block_addr);
                end
            end
        end
    end

    initial begin
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_data        <= '0;
        no_idle       = 1'b0;
        stall_request = 0;
        error_count   = 0;
        sent_count    = 0;
        checked_count = 0;
        slab_reset();
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_cases();
        test_mixed_traffic();
        test_output_stall();
        test_page_exhaustion();
        wait_drained();
        repeat (20) @(posedge aclk);
        $display("Requests %0d (alloc %0d, free %0d, realloc %0d, unused cmd %0d), results %0d",
                 sent_count, cmd_count[CMD_ALLOC], cmd_count[CMD_FREE],
                 cmd_count[CMD_REALLOC], cmd_count[CMD_NOP], checked_count);
        $display("Status ok %0d, no class %0d, out of pages %0d, unowned %0d; pages taken %0d/%0d",
                 status_count[ST_OK], status_count[ST_NO_CLASS], status_count[ST_NO_PAGE],
                 status_count[ST_UNOWNED], pages_taken, POOL_PAGES);
        if (error_count == 0) begin
            $display("** size_class_slab_allocator_top: PASSED **");
        end else begin
            $display("** size_class_slab_allocator_top: FAILED **");
        end
        $finish;
    end

endmodule
